// ----- hw/rtl/fts_pkg.sv -----
package fts_pkg;

  localparam int AccWidth   = 40;
  localparam int TimeWidth  = 32;
  localparam int RatioWidth = 8;
  localparam int TickWidth  = 9;
  localparam int CfgWidth   = 32;
  localparam int CfgIdxWidth = 2;

  localparam logic [AccWidth-1:0] AccMax = {AccWidth{1'b1}};

  localparam logic [CfgIdxWidth-1:0] REG_SERVER_MODE      = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_TICKS_PER_LEADER = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_STEP_LENGTH      = 2'd2;

  localparam logic [RatioWidth-1:0] RatioReset = 8'd1;
  localparam logic [TimeWidth-1:0]  StepReset  = 32'h0100_0000;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_SYNC   = 1'b1;

endpackage

// ----- hw/rtl/follower_tick_synchronizer_core.sv -----
// follower mode: load the input transaction, then one restoring divider step per
//   cycle over the 40-bit accumulator, then normalize, then the output register once free
// server mode goes from load straight to the output register; one transaction in flight,
//   next input taken once the result sits in the output register
// synchronous active-high reset clears the accumulator, the period tick count
//   and the registers to server_mode 0, ticks_per_leader 1, step_length 2^24
module follower_tick_synchronizer_core
  import fts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]    cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   req_type,
  input  logic [TimeWidth-1:0]   time_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TickWidth-1:0]   pending_ticks,
  output logic [RatioWidth-1:0]  tick_debt,
  output logic [AccWidth-1:0]    leftover_time
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_NORM = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam int CntWidth = $clog2(AccWidth);
  localparam logic [CntWidth-1:0] LastStep = CntWidth'(AccWidth - 1);

  logic [1:0]            state;
  logic                  server_mode;
  logic [RatioWidth-1:0] ticks_per_leader;
  logic [TimeWidth-1:0]  step_length;
  logic [AccWidth-1:0]   acc;
  logic [TickWidth-1:0]  ttp;
  logic                  kind;
  logic [AccWidth-1:0]   dvd;
  logic [TimeWidth-1:0]  rem;
  logic [CntWidth-1:0]   cnt;
  logic [TickWidth-1:0]  res_pend;
  logic [RatioWidth-1:0] res_debt;

  logic [RatioWidth-1:0] ratio;
  logic [TimeWidth-1:0]  step_eff;
  logic [AccWidth:0]     sum;
  logic [AccWidth-1:0]   acc_in;
  logic [RatioWidth-1:0] debt;
  logic [TimeWidth:0]    rem_sh;
  logic [TimeWidth:0]    diff;
  logic                  ge;
  logic [AccWidth:0]     total;
  logic                  over;
  logic [TickWidth-1:0]  upd_pend;
  logic                  out_free;

  assign ratio    = (ticks_per_leader == '0) ? RatioReset : ticks_per_leader;
  assign step_eff = (step_length == '0) ? TimeWidth'(1) : step_length;
  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    sum    = {1'b0, acc} + {{(AccWidth-TimeWidth+1){1'b0}}, time_value};
    acc_in = (req_type == REQ_SYNC) ? {{(AccWidth-TimeWidth){1'b0}}, time_value}
                                    : (sum[AccWidth] ? AccMax : sum[AccWidth-1:0]);
    debt   = '0;
    if (ttp != '0 && ttp < {1'b0, ratio}) begin
      debt = ratio - ttp[RatioWidth-1:0];
    end
    rem_sh = {rem, dvd[AccWidth-1]};
    diff   = rem_sh - {1'b0, step_eff};
    ge     = (rem_sh >= {1'b0, step_eff});
    total  = {1'b0, dvd} + {{(AccWidth+1-TickWidth){1'b0}}, ttp};
    over   = (total > {{(AccWidth+1-RatioWidth){1'b0}}, ratio});
    upd_pend = ({1'b0, ratio} > ttp) ? ({1'b0, ratio} - ttp) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      server_mode      <= 1'b0;
      ticks_per_leader <= RatioReset;
      step_length      <= StepReset;
      acc              <= '0;
      ttp              <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SERVER_MODE:      server_mode      <= cfg_data[0];
          REG_TICKS_PER_LEADER: ticks_per_leader <= cfg_data[RatioWidth-1:0];
          REG_STEP_LENGTH:      step_length      <= cfg_data[TimeWidth-1:0];
          default: ;
        endcase
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind     <= req_type;
            acc      <= acc_in;
            res_pend <= '0;
            res_debt <= '0;
            if (server_mode) begin
              if (req_type == REQ_SYNC) begin
                res_pend <= {1'b0, ratio};
                ttp      <= {1'b0, ratio};
              end
              state <= ST_FIN;
            end else begin
              if (req_type == REQ_SYNC) begin
                res_debt <= debt;
                ttp      <= {1'b0, debt} + TickWidth'(1);
              end
              dvd   <= acc_in;
              rem   <= '0;
              cnt   <= '0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem <= ge ? diff[TimeWidth-1:0] : rem_sh[TimeWidth-1:0];
          dvd <= {dvd[AccWidth-2:0], ge};
          cnt <= cnt + CntWidth'(1);
          if (cnt == LastStep) begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          acc <= {{(AccWidth-TimeWidth){1'b0}}, rem};
          if (over) begin
            ttp      <= {1'b0, ratio};
            res_pend <= (kind == REQ_SYNC) ? {1'b0, ratio} : upd_pend;
          end else begin
            ttp      <= total[TickWidth-1:0];
            res_pend <= (kind == REQ_SYNC) ? total[TickWidth-1:0] : dvd[TickWidth-1:0];
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            pending_ticks <= res_pend;
            tick_debt     <= res_debt;
            leftover_time <= acc;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
